>>> hdl/tse_pkg.sv
// Package for the Taylor series evaluator: field widths, series codes, types.
// No dependencies.
package tse_pkg;

  localparam int unsigned SumW = 48;

  typedef enum logic [1:0] {
    SER_EXP = 2'd0,
    SER_LN  = 2'd1,
    SER_SIN = 2'd2,
    SER_COS = 2'd3
  } series_t;

  // Request from the sequencer to the multiplier.
  typedef struct packed {
    logic            start;
    logic [SumW-1:0] a;
    logic [SumW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [SumW-1:0] prod;
  } mul_rsp_t;

endpackage

>>> hdl/tse_mul.sv
// Shared fixed-point multiplier: 48x48 magnitude product, one 24x48 partial
// product per cycle, rounded shift by the fraction width and saturation. Uses tse_pkg.
module tse_mul #(
  parameter int unsigned FracBits = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tse_pkg::mul_req_t req,
  output tse_pkg::mul_rsp_t rsp
);
  import tse_pkg::*;

  localparam int unsigned HalfW = SumW / 2;
  localparam int unsigned ProdW = 2 * SumW;

  logic [SumW-1:0]  ma_r, mb_r;
  logic             neg_r, busy_r, step_r, done_r;
  logic [ProdW-1:0] acc_r;
  logic [SumW-1:0]  prod_r;
  logic             ovf_r;

  logic [HalfW+SumW-1:0] pp;
  logic [ProdW-1:0]      acc_nxt, rnd;
  logic [ProdW-1:0]      shf;
  logic [SumW-1:0]       limit;
  logic                  sat;

  // one partial product per cycle: low half then high half of a
  assign pp = (step_r ? ma_r[SumW-1:HalfW] : ma_r[HalfW-1:0]) * mb_r;
  assign acc_nxt = step_r ? acc_r + ({{(ProdW-HalfW-SumW){1'b0}}, pp} << HalfW)
                          : {{(ProdW-HalfW-SumW){1'b0}}, pp};
  // rounding and saturation of the finished product
  assign rnd   = acc_r + (ProdW'(1) << (FracBits - 1));
  assign shf   = rnd >> FracBits;
  assign limit = neg_r ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
  assign sat   = (shf[ProdW-1:SumW] != '0) || (shf[SumW-1:0] > limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= 1'b0;
        neg_r  <= req.a[SumW-1] ^ req.b[SumW-1];
        ma_r   <= req.a[SumW-1] ? -req.a : req.a;
        mb_r   <= req.b[SumW-1] ? -req.b : req.b;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        if (step_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= ~step_r;
      end
    end
  end

  // final register: sign applied
  always_ff @(posedge clk) begin
    if (done_r) begin
      prod_r <= neg_r ? -(sat ? limit : shf[SumW-1:0]) : (sat ? limit : shf[SumW-1:0]);
      ovf_r  <= sat;
    end
  end

  logic fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) fin_r <= 1'b0;
    else        fin_r <= done_r;
  end

  assign rsp.done = fin_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.prod = prod_r;

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("multiplier done held two cycles");
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("multiplier busy while done");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> fin_r) else $error("result register missed");
endmodule

>>> hdl/tse_div.sv
// Restoring divider for term magnitudes: rounded quotient, one bit per cycle.
// Uses tse_pkg.
module tse_div #(
  parameter int unsigned DivW = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [tse_pkg::SumW-1:0] dividend,
  input  logic [DivW-1:0]          divisor,
  output logic                     done,
  output logic [tse_pkg::SumW-1:0] quot
);
  import tse_pkg::*;

  localparam int unsigned NumW = SumW + 1;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_r;
  logic [DivW:0]   rem_r;
  logic [DivW-1:0] d_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r, done_r, neg_r;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic [NumW-1:0] mag;

  assign mag   = dividend[SumW-1] ? -{1'b1, dividend} : {1'b0, dividend};
  assign trial = {rem_r[DivW-1:0], num_r[NumW-1]};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        neg_r  <= dividend[SumW-1];
        d_r    <= divisor;
        // add half the divisor for round to nearest
        num_r  <= mag + NumW'(divisor >> 1);
        rem_r  <= '0;
        cnt_r  <= CntW'(NumW);
      end else if (busy_r) begin
        if (!diff[DivW]) begin
          rem_r <= diff;
          num_r <= {num_r[NumW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          num_r <= {num_r[NumW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -num_r[SumW-1:0] : num_r[SumW-1:0];

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divider count ran out while busy");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done twice");
endmodule

>>> hdl/taylor_series_evaluator_unit.sv
// Taylor series evaluator (exp, ln(1+x), sin, cos): sequencer, sum and output.
// Uses tse_pkg, tse_mul, tse_div.
//
// Usage: one request beat on in_* (series code, argument in signed fixed point
// with FracBits fraction bits, term count) gives one result beat on out_* (the
// saturated partial sum and an overflow flag). Term counts below 3 act as 3,
// above MaxTerms as MaxTerms.
// Each term takes one multiply on the shared multiplier (two 24x48 partial
// products, then round and saturate) and one rounded division on the
// bit-serial divider, then an add into the saturated sum; sin and cos first
// compute x*x on the multiplier.
// The unit holds one request at a time; in_tready is low from acceptance until
// the result beat is taken. The result sits in an output register; while the
// receiver stalls it holds and no new request is taken.
// Reset (rst_n low, synchronous) returns to idle and drops out_tvalid.
module taylor_series_evaluator_unit #(
  parameter int unsigned FracBits = 24,
  parameter int unsigned MaxTerms = 19
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] req_type, [33:2] arg_value, [38:34] term_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [47:0] series_sum, [48] overflow_flag
);
  import tse_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxTerms + 1);
  localparam int unsigned DivW = $clog2(4 * MaxTerms * MaxTerms + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_X2   = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_ADD  = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  series_t         typ_r;
  logic [SumW-1:0] x_r, m_r, term_r, sum_r;
  logic [IdxW-1:0] i_r, n_r;
  logic            ovf_r, outv_r;
  logic [SumW-1:0] res_r;
  logic            reso_r;

  mul_req_t        mreq;
  mul_rsp_t        mrsp;
  logic            dstart, ddone;
  logic [SumW-1:0] dnum, dq;
  logic [DivW-1:0] dden;
  logic [DivW-1:0] i2;
  logic [SumW-1:0] nprod, nq, addend;
  logic            nprod_ovf, nq_ovf;
  logic [SumW:0]   s_ext;
  logic [SumW-1:0] s_sat;
  logic            s_ovf;
  logic [4:0]      tc;
  logic [SumW-1:0] one;
  logic            last;

  tse_mul #(.FracBits(FracBits)) u_mul (.clk, .rst_n, .req(mreq), .rsp(mrsp));
  tse_div #(.DivW(DivW)) u_div (.clk, .rst_n, .start(dstart), .dividend(dnum),
    .divisor(dden), .done(ddone), .quot(dq));

  assign one = SumW'(1) << FracBits;
  assign tc  = in_tdata[38:34];
  assign i2  = DivW'({i_r, 1'b0});
  assign last = (i_r == n_r - 1'b1);

  // saturating negate of product and of quotient
  assign nprod_ovf = (mrsp.prod == {1'b1, {(SumW-1){1'b0}}});
  assign nprod     = nprod_ovf ? {1'b0, {(SumW-1){1'b1}}} : -mrsp.prod;
  assign nq_ovf    = (dq == {1'b1, {(SumW-1){1'b0}}});
  assign nq        = nq_ovf ? {1'b0, {(SumW-1){1'b1}}} : -dq;

  // divisor and dividend by series; dividend taken straight off the product (negated for ln)
  always_comb begin
    unique case (typ_r)
      SER_EXP: dden = DivW'(i_r);
      SER_LN:  dden = DivW'(i_r) + DivW'(1);
      SER_SIN: dden = i2 * (i2 + DivW'(1));
      default: dden = (i2 - DivW'(1)) * i2;
    endcase
  end
  assign dnum   = (typ_r == SER_LN) ? nprod : mrsp.prod;
  assign dstart = (state_r == S_DIV) && mrsp.done;

  // saturated sum
  assign addend = ((typ_r == SER_SIN) || (typ_r == SER_COS)) ? nq : dq;
  assign s_ext  = {sum_r[SumW-1], sum_r} + {addend[SumW-1], addend};
  assign s_ovf  = s_ext[SumW] != s_ext[SumW-1];
  assign s_sat  = s_ovf ? (s_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}}
                                       : {1'b0, {(SumW-1){1'b1}}}) : s_ext[SumW-1:0];

  // multiplier operands
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = term_r;
    mreq.b     = ((typ_r == SER_SIN) || (typ_r == SER_COS)) ? m_r : x_r;
    if (state_r == S_X2) begin
      mreq.a = x_r;
      mreq.b = x_r;
    end
    if (in_tvalid && in_tready && ((in_tdata[1:0] == SER_SIN) || (in_tdata[1:0] == SER_COS)))
      mreq.start = 1'b0;
    if (state_r == S_MUL) mreq.start = 1'b1;
    if (state_r == S_X2 && !mrsp.done && i_r == '0) mreq.start = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        state_nxt = ((in_tdata[1:0] == SER_SIN) || (in_tdata[1:0] == SER_COS)) ? S_X2 : S_MUL;
      end
      S_X2:   if (mrsp.done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (ddone) state_nxt = S_ADD;
      S_ADD:  state_nxt = last ? S_OUT : S_MUL;
      S_OUT:  state_nxt = S_WAIT;
      S_WAIT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outv_r  <= 1'b0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          typ_r <= series_t'(in_tdata[1:0]);
          x_r   <= SumW'(signed'(in_tdata[33:2]));
          n_r   <= (tc < 5'd3) ? IdxW'(3) :
                   (32'(tc) > MaxTerms) ? IdxW'(MaxTerms) : IdxW'(tc);
          ovf_r <= 1'b0;
          i_r   <= '0;
          if ((in_tdata[1:0] == SER_EXP) || (in_tdata[1:0] == SER_COS)) begin
            term_r <= one;
            sum_r  <= one;
          end else begin
            term_r <= SumW'(signed'(in_tdata[33:2]));
            sum_r  <= SumW'(signed'(in_tdata[33:2]));
          end
        end
        S_X2: begin
          if (mrsp.done) begin
            m_r   <= mrsp.prod;
            ovf_r <= ovf_r | mrsp.ovf;
          end
          i_r <= IdxW'(1);
        end
        S_MUL: if (i_r == '0) i_r <= IdxW'(1);
        S_DIV: if (mrsp.done) begin
          ovf_r <= ovf_r | mrsp.ovf | ((typ_r == SER_LN) && nprod_ovf);
          if (typ_r == SER_LN) term_r <= nprod;
          else if (typ_r == SER_EXP) m_r <= mrsp.prod;
          else x_r <= mrsp.prod;
        end
        S_ADD: begin
          sum_r <= s_sat;
          ovf_r <= ovf_r | s_ovf | (((typ_r == SER_SIN) || (typ_r == SER_COS)) && nq_ovf);
          if (typ_r != SER_LN) term_r <= ((typ_r == SER_SIN) || (typ_r == SER_COS)) ? nq : dq;
          i_r <= i_r + 1'b1;
        end
        S_OUT: begin
          res_r  <= sum_r;
          reso_r <= ovf_r;
          outv_r <= 1'b1;
        end
        S_WAIT: if (out_tready) outv_r <= 1'b0;
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = outv_r;
  assign out_tdata  = {7'd0, reso_r, res_r};

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_valid_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == S_WAIT) else $error("result shown outside wait");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("request taken while result pending");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> i_r < n_r) else $error("term index past count");
endmodule
